// ----- rtl/u8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8sd_pkg;

  // Byte classification masks and patterns.
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_PAT     = 8'h80;
  localparam logic [7:0] LEAD2_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_PAT    = 8'hC0;
  localparam logic [7:0] LEAD3_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_PAT    = 8'hE0;
  localparam logic [7:0] LEAD2_BITS   = 8'h1F;
  localparam logic [7:0] LEAD3_BITS   = 8'h0F;
  localparam logic [7:0] CONT_BITS    = 8'h3F;

  // Most results one input byte can cause.
  localparam int unsigned MAX_RES = 3;

  // Number of held bytes.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_LEAD = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // Source byte counts of a result.
  localparam logic [1:0] NB_ONE   = 2'd1;
  localparam logic [1:0] NB_TWO   = 2'd2;
  localparam logic [1:0] NB_THREE = 2'd3;

  // Partial sequence held between bytes.
  typedef struct packed {
    logic [7:0] held_lead;
    logic [7:0] held_cont;
    logic [1:0] held_count;
  } u8sd_state_t;

  // One result word.
  typedef struct packed {
    logic        last_of_run;
    logic [1:0]  bytes_consumed;
    logic [15:0] code_point;
  } u8sd_res_t;

  // Everything the decoder hands to the output queue for one byte.
  typedef struct packed {
    logic [1:0] res_count;
    u8sd_res_t  res2;
    u8sd_res_t  res1;
    u8sd_res_t  res0;
  } u8sd_dec_t;

endpackage

// ----- rtl/u8sd_decode.sv -----
// ----------------------------------------------------------------------------
// u8sd_decode
// Combinational decode of one byte against the held partial sequence:
// produces up to three result words and the next held state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sd_decode
  import u8sd_pkg::*;
(
  input  u8sd_state_t state_cur,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output u8sd_state_t state_nxt,
  output u8sd_dec_t   dec
);

  u8sd_res_t  res [MAX_RES];
  logic [1:0] n;
  logic [1:0] last_idx;
  logic       do_fresh;
  logic       is_cont;
  logic       is_lead;
  u8sd_state_t st;

  assign is_cont = (data_byte & CONT_MASK) == CONT_PAT;
  assign is_lead = ((data_byte & LEAD2_MASK) == LEAD2_PAT) ||
                   ((data_byte & LEAD3_MASK) == LEAD3_PAT);

  // Results are appended in order; the count never passes three.
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    n        = 2'd0;
    do_fresh = 1'b0;
    st       = state_cur;

    if (st.held_count == HELD_NONE) begin
      do_fresh = 1'b1;
    end else if (is_cont) begin
      if (st.held_count == HELD_LEAD && (st.held_lead & LEAD2_MASK) == LEAD2_PAT) begin
        // Two-byte sequence completes.
        res[n].code_point     = {5'd0, st.held_lead[4:0], data_byte[5:0]};
        res[n].bytes_consumed = NB_TWO;
        n  = n + 2'd1;
        st = '0;
      end else if (st.held_count == HELD_LEAD) begin
        st.held_cont  = data_byte;
        st.held_count = HELD_TWO;
      end else begin
        // Three-byte sequence completes.
        res[n].code_point     = {st.held_lead[3:0], st.held_cont[5:0], data_byte[5:0]};
        res[n].bytes_consumed = NB_THREE;
        n  = n + 2'd1;
        st = '0;
      end
    end else begin
      // Missing continuation: release held bytes singly, then start over.
      res[n].code_point     = {8'd0, st.held_lead};
      res[n].bytes_consumed = NB_ONE;
      n = n + 2'd1;
      if (st.held_count >= HELD_TWO) begin
        res[n].code_point     = {8'd0, st.held_cont};
        res[n].bytes_consumed = NB_ONE;
        n = n + 2'd1;
      end
      st       = '0;
      do_fresh = 1'b1;
    end

    // Fresh byte with nothing held.
    if (do_fresh) begin
      if (data_byte < ASCII_LIMIT || !is_lead) begin
        res[n].code_point     = {8'd0, data_byte};
        res[n].bytes_consumed = NB_ONE;
        n = n + 2'd1;
      end else begin
        st.held_lead  = data_byte;
        st.held_cont  = 8'd0;
        st.held_count = HELD_LEAD;
      end
    end

    // End of text flushes whatever is still held.
    if (end_of_text) begin
      if (st.held_count >= HELD_LEAD && n < 2'd3) begin
        res[n].code_point     = {8'd0, st.held_lead};
        res[n].bytes_consumed = NB_ONE;
        n = n + 2'd1;
      end
      if (st.held_count >= HELD_TWO && n < 2'd3) begin
        res[n].code_point     = {8'd0, st.held_cont};
        res[n].bytes_consumed = NB_ONE;
        n = n + 2'd1;
      end
      st = '0;
    end

    // Mark the final result of this byte.
    last_idx = n - 2'd1;
    if (n != 2'd0) begin
      res[last_idx].last_of_run = 1'b1;
    end
  end

  assign state_nxt     = st;
  assign dec.res_count = n;
  assign dec.res0      = res[0];
  assign dec.res1      = res[1];
  assign dec.res2      = res[2];

endmodule

// ----- rtl/u8sd_outq.sv -----
// ----------------------------------------------------------------------------
// u8sd_outq
// Four-word result queue that takes up to three words in one cycle and
// drives the result stream one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sd_outq
  import u8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u8sd_dec_t  dec,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output u8sd_res_t  out_word
);

  localparam int unsigned DEPTH = 4;

  u8sd_res_t  q_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [3:0] fill_after;
  u8sd_res_t  wr_word [MAX_RES];

  assign wr_word[0] = dec.res0;
  assign wr_word[1] = dec.res1;
  assign wr_word[2] = dec.res2;

  assign out_valid = count_r != 3'd0;
  assign out_word  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Room when this cycle's words fit after any pop.
  assign fill_after = {1'b0, count_r} - {3'd0, pop} + {2'd0, dec.res_count};
  assign room       = fill_after <= 4'(DEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + dec.res_count;
      count_nxt  = count_nxt + {1'b0, dec.res_count};
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 2'd1;
      count_nxt  = count_nxt - 3'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < dec.res_count) begin
          q_r[wr_ptr_r + 2'(i)] <= wr_word[i];
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH))
    else $error("result queue overfilled");
  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[1:0])
    else $error("queue pointers disagree with fill count");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("push without room");
`endif

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point stream, sequences of up to three bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one text byte per word in in_tdata; in_tlast
//   marks the last byte of a string and flushes any partial sequence.
//   The result stream carries one code point per word, with the number of
//   source bytes it stands for; out_tlast marks the final word caused by
//   a given input byte. Bytes that complete no code point give no word.
//   A byte taken lands in the input register and is decoded there; once
//   the queue has room, its words join the queue that drives the output.
//   Throughput: one byte per cycle, set by the combinational decode between
//   the input register and a four-word result queue. Malformed input can
//   give up to three words for one byte; those drain one per cycle while
//   the receiver is ready, and the input holds off only while the queue
//   lacks room for a decoded byte. When the receiver stalls, the queue fills
//   and in_tready drops; nothing is lost. Reset empties the input register
//   and the queue and clears the held partial sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] code_point, [17:16] bytes_consumed, zero fill
  output logic        out_tlast   // last_of_run
);

  logic        s_valid_r, s_valid_nxt;
  logic [7:0]  s_byte_r;
  logic        s_eot_r;
  u8sd_state_t state_r, state_nxt;
  u8sd_dec_t   dec;
  logic        room;
  logic        fire;
  u8sd_res_t   out_word;

  u8sd_decode u_decode (
    .state_cur   (state_r),
    .data_byte   (s_byte_r),
    .end_of_text (s_eot_r),
    .state_nxt   (state_nxt),
    .dec         (dec)
  );

  u8sd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .dec       (dec),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  // Decode the registered byte once its results fit in the queue.
  assign fire        = s_valid_r && room;
  assign in_tready   = !s_valid_r || fire;
  assign s_valid_nxt = (in_tvalid && in_tready) || (s_valid_r && !fire);

  // Input register and held sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      state_r   <= '0;
    end else begin
      s_valid_r <= s_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_byte_r <= in_tdata;
      s_eot_r  <= in_tlast;
    end
  end

  // Result stream packing.
  assign out_tdata = {6'd0, out_word.bytes_consumed, out_word.code_point};
  assign out_tlast = out_word.last_of_run;

`ifndef ASSERT_OFF
  a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.held_count != NB_THREE)
    else $error("held count out of range");
  a_cont_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.held_count != HELD_TWO) |-> (state_r.held_cont == 8'd0))
    else $error("stale held continuation byte");
  a_lead_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.held_count == HELD_NONE) |-> (state_r.held_lead == 8'd0))
    else $error("stale held lead byte");
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("held state changed without a decode");
`endif

endmodule

// ----- bench/utf8_stream_decoder_check.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_check
// Watches both streams of the UTF-8 decoder, predicts every result word from
// the accepted input bytes and compares the words that come out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_check
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_text
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [15:0] code_point, [17:16] bytes_consumed, zero fill
  input  logic        out_tlast,  // last_of_run
  output int          fail_count,
  output int          pending,
  output int          words_seen,
  output int          multi_seen
);

  // Partial sequence as the decoder should be holding it.
  logic [7:0] lead_byte;
  logic [7:0] mid_byte;
  logic [1:0] held_n;

  // Words caused by the current byte, and all words still to come.
  u8sd_res_t  run_q[$];
  u8sd_res_t  cp_expect_q[$];

  function automatic u8sd_res_t make_word(input logic [15:0] cp, input logic [1:0] nb);
    u8sd_res_t w;
    w.code_point     = cp;
    w.bytes_consumed = nb;
    w.last_of_run    = 1'b0;
    return w;
  endfunction

  // Emit whatever is held as raw single bytes, lead first.
  task flush_held();
    if (held_n != HELD_NONE) run_q.push_back(make_word({8'h00, lead_byte}, NB_ONE));
    if (held_n >= HELD_TWO) run_q.push_back(make_word({8'h00, mid_byte}, NB_ONE));
    lead_byte = 8'h00;
    mid_byte  = 8'h00;
    held_n    = HELD_NONE;
  endtask

  // Handle a byte with nothing held: ASCII and junk go straight out, leads wait.
  task start_byte(input logic [7:0] b);
    if (b < ASCII_LIMIT) begin
      run_q.push_back(make_word({8'h00, b}, NB_ONE));
    end else if ((b & LEAD2_MASK) == LEAD2_PAT || (b & LEAD3_MASK) == LEAD3_PAT) begin
      lead_byte = b;
      mid_byte  = 8'h00;
      held_n    = HELD_LEAD;
    end else begin
      run_q.push_back(make_word({8'h00, b}, NB_ONE));
    end
  endtask

  task decode_byte(input logic [7:0] b, input logic eot);
    logic [15:0] cp;
    run_q.delete();
    if (held_n == HELD_NONE) begin
      start_byte(b);
    end else if ((b & CONT_MASK) == CONT_PAT) begin
      if (held_n == HELD_LEAD && (lead_byte & LEAD2_MASK) == LEAD2_PAT) begin
        cp = ({8'h00, lead_byte & LEAD2_BITS} << 6) | {8'h00, b & CONT_BITS};
        run_q.push_back(make_word(cp, NB_TWO));
        lead_byte = 8'h00;
        mid_byte  = 8'h00;
        held_n    = HELD_NONE;
      end else if (held_n == HELD_LEAD) begin
        mid_byte = b;
        held_n   = HELD_TWO;
      end else begin
        cp = ({8'h00, lead_byte & LEAD3_BITS} << 12)
           | ({8'h00, mid_byte & CONT_BITS} << 6)
           | {8'h00, b & CONT_BITS};
        run_q.push_back(make_word(cp, NB_THREE));
        lead_byte = 8'h00;
        mid_byte  = 8'h00;
        held_n    = HELD_NONE;
      end
    end else begin
      // Missing continuation: give back the held bytes, then start over.
      flush_held();
      start_byte(b);
    end
    if (eot) flush_held();
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[i]) cp_expect_q.push_back(run_q[i]);
  endtask

  task note_error(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s, got cp=%h nb=%0d fill=%h last=%b", $realtime, what,
               out_tdata[15:0], out_tdata[17:16], out_tdata[23:18], out_tlast);
    end
  endtask

  // Predict on accepted bytes, compare on accepted words.
  always @(posedge clk) begin
    u8sd_res_t want;
    if (!rst_n) begin
      lead_byte = 8'h00;
      mid_byte  = 8'h00;
      held_n    = HELD_NONE;
      cp_expect_q.delete();
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (cp_expect_q.size() == 0) begin
          note_error("no word expected");
        end else begin
          want = cp_expect_q.pop_front();
          if (want.bytes_consumed != NB_ONE) multi_seen++;
          if (out_tdata[15:0] !== want.code_point || out_tdata[17:16] !== want.bytes_consumed ||
              out_tdata[23:18] !== 6'd0 || out_tlast !== want.last_of_run) begin
            note_error($sformatf("expected cp=%h nb=%0d fill=00 last=%b", want.code_point,
                                 want.bytes_consumed, want.last_of_run));
          end
        end
      end
      pending <= cp_expect_q.size();
    end
  end

endmodule

// ----- bench/utf8_stream_decoder_test.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Drives the UTF-8 decoder with directed edge cases and then random text made
// mostly of well-formed sequences mixed with junk, truncated sequences and
// early string ends, with random gaps and output stalls. The checker beside
// the decoder predicts and compares every word; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
  import u8sd_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  int          fail_count;
  int          pending;
  int          words_seen;
  int          multi_seen;

  // Idle controls for the sending and the receiving side.
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int          stall_left = 0;
  int          byte_count = 0;
  int          string_count = 0;

  utf8_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  utf8_stream_decoder_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .words_seen (words_seen),
    .multi_seen (multi_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one word and hold it until the decoder takes it.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (gaps_on && in_tvalid && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    byte_count++;
    if (eot) string_count++;
  endtask

  // Stop sending until every predicted word has come out.
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic pick_eot();
    return $urandom_range(0, 15) == 0;
  endfunction

  function automatic logic [7:0] pick_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // A byte that breaks a pending sequence: ASCII or another lead.
  function automatic logic [7:0] pick_breaker();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h00, 8'h7F));
    return 8'($urandom_range(8'hC0, 8'hEF));
  endfunction

  initial begin
    int rand_bytes;
    int stretch;
    int guard;
    bit paused;
    rand_bytes = 0;
    stretch    = -1;
    guard      = 0;
    paused     = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, overlong and maximal forms, junk bytes,
    // missing continuations and string ends that flush a partial sequence.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
    drain_wait();

    // Random text, idling chosen per stretch and switched off near the end.
    while (rand_bytes < 250) begin
      if (rand_bytes >= 210) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else if (rand_bytes / 50 != stretch) begin
        stretch   = rand_bytes / 50;
        gaps_on   = $urandom_range(0, 2) != 0;
        stalls_on = $urandom_range(0, 2) != 0;
      end
      if (!paused && rand_bytes >= 120) begin
        paused = 1'b1;
        drain_wait();
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          send_byte(8'($urandom_range(8'h00, 8'h7F)), pick_eot());
          rand_bytes += 1;
        end
        6, 7, 8, 9: begin
          send_byte(8'($urandom_range(8'hC0, 8'hDF)), pick_eot());
          send_byte(pick_cont(), pick_eot());
          rand_bytes += 2;
        end
        10, 11, 12, 13: begin
          send_byte(8'($urandom_range(8'hE0, 8'hEF)), pick_eot());
          send_byte(pick_cont(), pick_eot());
          send_byte(pick_cont(), pick_eot());
          rand_bytes += 3;
        end
        14: begin
          send_byte(pick_cont(), pick_eot());
          rand_bytes += 1;
        end
        15: begin
          send_byte(8'($urandom_range(8'hF0, 8'hFF)), pick_eot());
          rand_bytes += 1;
        end
        16: begin
          send_byte(8'($urandom_range(8'hC0, 8'hDF)), pick_eot());
          send_byte(pick_breaker(), pick_eot());
          rand_bytes += 2;
        end
        17: begin
          send_byte(8'($urandom_range(8'hE0, 8'hEF)), pick_eot());
          send_byte(pick_cont(), pick_eot());
          send_byte(pick_breaker(), pick_eot());
          rand_bytes += 3;
        end
        18: begin
          send_byte(8'($urandom_range(8'hE0, 8'hEF)), pick_eot());
          send_byte(pick_breaker(), pick_eot());
          rand_bytes += 2;
        end
        default: begin
          send_byte(8'($urandom), pick_eot());
          rand_bytes += 1;
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // Let the result queue drain, then watch a little longer for strays.
    @(posedge clk);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d terminated strings; checked %0d result words,",
             byte_count, string_count, words_seen);
    $display("%0d of them multi-byte code points; %0d words still expected at the end.",
             multi_seen, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #1ms;
    $display("simulation failed");
    $finish;
  end

endmodule
